@@ rtl/core/tri_perim_pkg.sv @@
// Shared widths, constants and cell data types for the triangle perimeter core.
package tri_perim_pkg;

    localparam int COORD_WIDTH = 16;
    localparam int DIFF_WIDTH  = COORD_WIDTH + 1;
    localparam int SQ_WIDTH    = 2 * DIFF_WIDTH;
    localparam int SUM_WIDTH   = SQ_WIDTH + 1;
    localparam int SIDE_WIDTH  = COORD_WIDTH + 1;
    localparam int PERIM_WIDTH = COORD_WIDTH + 3;
    localparam int ROOT_STEPS  = (SUM_WIDTH + 1) / 2;
    localparam int REM_WIDTH   = ROOT_STEPS + 2;
    localparam int PAD_WIDTH   = 2 * ROOT_STEPS;

    localparam int NUM_SIDES   = 3;

    // One side's square root in flight: the bits of the radicand not yet
    // consumed, the partial remainder and the partial root.
    typedef struct packed {
        logic [PAD_WIDTH-1:0]  radicand;
        logic [REM_WIDTH-1:0]  remainder;
        logic [SIDE_WIDTH-1:0] root;
    } root_lane_t;

    // What one cell of the chain holds for one triangle.
    typedef struct packed {
        logic                           valid;
        root_lane_t [NUM_SIDES-1:0]     lane;
    } cell_data_t;

endpackage

@@ rtl/core/tri_perim_cell.sv @@
// One cell of the square root chain: one restoring step for all three sides.
module tri_perim_cell
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      advance,
    input  tri_perim_pkg::cell_data_t cell_in,
    output tri_perim_pkg::cell_data_t cell_out
);

    tri_perim_pkg::cell_data_t data_next;
    logic                      valid_reg;
    tri_perim_pkg::root_lane_t [tri_perim_pkg::NUM_SIDES-1:0] lane_reg;

    always_comb
    begin
        logic [tri_perim_pkg::REM_WIDTH-1:0] trial_rem;
        logic [tri_perim_pkg::REM_WIDTH-1:0] trial_sub;
        data_next = cell_in;
        for (int s = 0; s < tri_perim_pkg::NUM_SIDES; s++)
        begin
            trial_rem = {cell_in.lane[s].remainder[tri_perim_pkg::REM_WIDTH-3:0],
                         cell_in.lane[s].radicand[tri_perim_pkg::PAD_WIDTH-1 -: 2]};
            trial_sub = {cell_in.lane[s].root, 2'b01};
            data_next.lane[s].radicand = {cell_in.lane[s].radicand[tri_perim_pkg::PAD_WIDTH-3:0],
                                          2'b00};
            if (trial_rem >= trial_sub)
            begin
                data_next.lane[s].remainder = trial_rem - trial_sub;
                data_next.lane[s].root = {cell_in.lane[s].root[tri_perim_pkg::SIDE_WIDTH-2:0],
                                          1'b1};
            end
            else
            begin
                data_next.lane[s].remainder = trial_rem;
                data_next.lane[s].root = {cell_in.lane[s].root[tri_perim_pkg::SIDE_WIDTH-2:0],
                                          1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= data_next.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            lane_reg <= data_next.lane;
        end
    end

    assign cell_out.valid = valid_reg;
    assign cell_out.lane  = lane_reg;

endmodule

@@ rtl/core/tri_perim_front.sv @@
// Front end: coordinate differences, their squares and the sums of squares.
module tri_perim_front
(
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      advance,
    input  logic                                      in_valid,
    input  logic signed [tri_perim_pkg::COORD_WIDTH-1:0] ax,
    input  logic signed [tri_perim_pkg::COORD_WIDTH-1:0] ay,
    input  logic signed [tri_perim_pkg::COORD_WIDTH-1:0] bx,
    input  logic signed [tri_perim_pkg::COORD_WIDTH-1:0] by,
    input  logic signed [tri_perim_pkg::COORD_WIDTH-1:0] cx,
    input  logic signed [tri_perim_pkg::COORD_WIDTH-1:0] cy,
    output tri_perim_pkg::cell_data_t                 cell_out
);

    localparam int DW = tri_perim_pkg::DIFF_WIDTH;
    localparam int SW = tri_perim_pkg::SQ_WIDTH;

    // Stage one registers the absolute differences, stage two the sums of squares.
    logic                          valid1_reg;
    logic [DW-2:0]                 dx_reg [tri_perim_pkg::NUM_SIDES];
    logic [DW-2:0]                 dy_reg [tri_perim_pkg::NUM_SIDES];
    logic [DW-2:0]                 dx_next [tri_perim_pkg::NUM_SIDES];
    logic [DW-2:0]                 dy_next [tri_perim_pkg::NUM_SIDES];
    logic                          valid2_reg;
    logic [tri_perim_pkg::SUM_WIDTH-1:0] sum_reg [tri_perim_pkg::NUM_SIDES];

    function automatic logic [DW-2:0] abs_diff(
        input logic signed [tri_perim_pkg::COORD_WIDTH-1:0] p,
        input logic signed [tri_perim_pkg::COORD_WIDTH-1:0] q
    );
        logic signed [DW-1:0] d;
        logic        [DW-1:0] m;
        d = DW'(q) - DW'(p);
        m = d[DW-1] ? (~d + 1'b1) : d;
        // Magnitude never exceeds 2^COORD_WIDTH - 1.
        return m[DW-2:0];
    endfunction

    always_comb
    begin
        dx_next[0] = abs_diff(ax, bx);
        dy_next[0] = abs_diff(ay, by);
        dx_next[1] = abs_diff(bx, cx);
        dy_next[1] = abs_diff(by, cy);
        dx_next[2] = abs_diff(cx, ax);
        dy_next[2] = abs_diff(cy, ay);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid1_reg <= 1'b0;
            valid2_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid1_reg <= in_valid;
            valid2_reg <= valid1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            for (int s = 0; s < tri_perim_pkg::NUM_SIDES; s++)
            begin
                dx_reg[s]  <= dx_next[s];
                dy_reg[s]  <= dy_next[s];
                sum_reg[s] <= tri_perim_pkg::SUM_WIDTH'(SW'(dx_reg[s]) * SW'(dx_reg[s]))
                            + tri_perim_pkg::SUM_WIDTH'(SW'(dy_reg[s]) * SW'(dy_reg[s]));
            end
        end
    end

    always_comb
    begin
        cell_out.valid = valid2_reg;
        for (int s = 0; s < tri_perim_pkg::NUM_SIDES; s++)
        begin
            cell_out.lane[s].radicand  = tri_perim_pkg::PAD_WIDTH'(sum_reg[s]);
            cell_out.lane[s].remainder = '0;
            cell_out.lane[s].root      = '0;
        end
    end

endmodule

@@ rtl/core/triangle_perimeter_core.sv @@
// Top level of the triangle perimeter core: front end, square root chain, output stage.
//
// The core takes one triangle word per cycle and returns its three floor
// Euclidean side lengths and their sum as one result word, with no state kept
// between words. Every word passes through a fixed pipeline: two front-end
// stages (absolute differences, then sums of squares), a chain of
// ROOT_STEPS square root cells (18 at a 16-bit coordinate width), each
// resolving one root bit for all three sides, and one output register that
// also forms the perimeter. The sustained rate is one triangle per cycle while
// the output is not stalled. The whole pipeline moves as one: it advances
// whenever the output register is empty or is being taken in that cycle, and
// holds otherwise. While the output register holds a stalled result, the
// input is stalled too, even if earlier stages are empty.
module triangle_perimeter_core
(
    input  logic                                         clk,
    input  logic                                         rst_n,
    input  logic                                         in_valid,
    output logic                                         in_stall,
    input  logic signed [tri_perim_pkg::COORD_WIDTH-1:0] vertex_a_x,
    input  logic signed [tri_perim_pkg::COORD_WIDTH-1:0] vertex_a_y,
    input  logic signed [tri_perim_pkg::COORD_WIDTH-1:0] vertex_b_x,
    input  logic signed [tri_perim_pkg::COORD_WIDTH-1:0] vertex_b_y,
    input  logic signed [tri_perim_pkg::COORD_WIDTH-1:0] vertex_c_x,
    input  logic signed [tri_perim_pkg::COORD_WIDTH-1:0] vertex_c_y,
    output logic                                         out_valid,
    input  logic                                         out_stall,
    output logic [tri_perim_pkg::SIDE_WIDTH-1:0]         side_ab,
    output logic [tri_perim_pkg::SIDE_WIDTH-1:0]         side_bc,
    output logic [tri_perim_pkg::SIDE_WIDTH-1:0]         side_ca,
    output logic [tri_perim_pkg::PERIM_WIDTH-1:0]        perimeter
);

    localparam int STEPS = tri_perim_pkg::ROOT_STEPS;

    tri_perim_pkg::cell_data_t chain [STEPS+1];

    logic advance;
    logic out_valid_reg;
    logic [tri_perim_pkg::SIDE_WIDTH-1:0]  side_ab_reg;
    logic [tri_perim_pkg::SIDE_WIDTH-1:0]  side_bc_reg;
    logic [tri_perim_pkg::SIDE_WIDTH-1:0]  side_ca_reg;
    logic [tri_perim_pkg::PERIM_WIDTH-1:0] perimeter_reg;

    // The whole pipe moves together; it may move whenever the output register
    // is empty or is being taken this cycle.
    assign advance  = !out_valid_reg || !out_stall;
    assign in_stall = !advance;

    tri_perim_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .advance  (advance),
        .in_valid (in_valid),
        .ax       (vertex_a_x),
        .ay       (vertex_a_y),
        .bx       (vertex_b_x),
        .by       (vertex_b_y),
        .cx       (vertex_c_x),
        .cy       (vertex_c_y),
        .cell_out (chain[0])
    );

    // One cell per root bit, most significant bit first.
    for (genvar k = 0; k < STEPS; k++)
    begin : g_cell
        tri_perim_cell u_cell
        (
            .clk      (clk),
            .rst_n    (rst_n),
            .advance  (advance),
            .cell_in  (chain[k]),
            .cell_out (chain[k+1])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= chain[STEPS].valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            side_ab_reg   <= chain[STEPS].lane[0].root;
            side_bc_reg   <= chain[STEPS].lane[1].root;
            side_ca_reg   <= chain[STEPS].lane[2].root;
            perimeter_reg <= tri_perim_pkg::PERIM_WIDTH'(chain[STEPS].lane[0].root)
                           + tri_perim_pkg::PERIM_WIDTH'(chain[STEPS].lane[1].root)
                           + tri_perim_pkg::PERIM_WIDTH'(chain[STEPS].lane[2].root);
        end
    end

    assign out_valid = out_valid_reg;
    assign side_ab   = side_ab_reg;
    assign side_bc   = side_bc_reg;
    assign side_ca   = side_ca_reg;
    assign perimeter = perimeter_reg;

endmodule
